>>> design/tsst_pkg.sv
`default_nettype none

package tsst_pkg;

   localparam int TSST_DEPTH = 64;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [2:0] STATUS_INSERTED = 3'd0;
   localparam logic [2:0] STATUS_REPLACED = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_FOUND    = 3'd3;
   localparam logic [2:0] STATUS_DEFAULT  = 3'd4;

   localparam logic [31:0] DEFAULT_POSITION    = 32'd0;
   localparam logic [7:0]  DEFAULT_NUMERATOR   = 8'd4;
   localparam logic [7:0]  DEFAULT_DENOMINATOR = 8'd4;

   typedef struct packed {
      logic        mode;
      logic [31:0] position;
      logic [7:0]  numerator_in;
      logic [7:0]  denominator_in;
   } tsst_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] event_position;
      logic [7:0]  numerator_out;
      logic [7:0]  denominator_out;
   } tsst_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] position;
      logic [7:0]  numerator;
      logic [7:0]  denominator;
   } tsst_entry_type;

   // per-cycle commands broadcast along the row
   typedef struct packed {
      logic compare;
      logic do_replace;
      logic do_insert;
   } tsst_ctrl_type;

   typedef struct packed {
      logic        any_eq;
      logic        full;
      logic        found;
      logic [31:0] position;
      logic [7:0]  numerator;
      logic [7:0]  denominator;
   } tsst_chain_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY
   } tsst_state_type;

endpackage

`default_nettype wire

>>> design/tsst_cell.sv
`default_nettype none

module tsst_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tsst_pkg::tsst_ctrl_type  ctrl,
   input  tsst_pkg::tsst_req_type   cmd,
   input  tsst_pkg::tsst_entry_type prev_entry,
   input  logic                    prev_lt,
   output tsst_pkg::tsst_entry_type entry,
   output logic                    lt,
   output logic                    eq
);
   import tsst_pkg::*;

   logic           valid_ff, valid_in;
   tsst_entry_type data_ff, data_in;
   logic           lt_ff, lt_in;
   logic           eq_ff, eq_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctrl.compare) begin
         lt_in = valid_ff && (data_ff.position < cmd.position);
         eq_in = valid_ff && (data_ff.position == cmd.position);
      end
      if (ctrl.do_replace && eq_ff) begin
         data_in.numerator   = cmd.numerator_in;
         data_in.denominator = cmd.denominator_in;
      end
      // cells at or above the slot move up one; the slot itself takes the new word
      if (ctrl.do_insert && !lt_ff) begin
         if (prev_lt) begin
            valid_in            = 1'b1;
            data_in.position    = cmd.position;
            data_in.numerator   = cmd.numerator_in;
            data_in.denominator = cmd.denominator_in;
         end else begin
            valid_in = prev_entry.valid;
            data_in  = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lt_ff    <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         lt_ff    <= lt_in;
         eq_ff    <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      entry       = data_ff;
      entry.valid = valid_ff;
   end

   assign lt = lt_ff;
   assign eq = eq_ff;

endmodule

`default_nettype wire

>>> design/tsst_chain.sv
`default_nettype none

module tsst_chain #(
   parameter int TABLE_DEPTH = tsst_pkg::TSST_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tsst_pkg::tsst_ctrl_type         ctrl,
   input  tsst_pkg::tsst_req_type          cmd,
   output tsst_pkg::tsst_chain_status_type stat
);
   import tsst_pkg::*;

   tsst_entry_type entry   [TABLE_DEPTH];
   logic           lt      [TABLE_DEPTH];
   logic           eq      [TABLE_DEPTH];
   logic           le      [TABLE_DEPTH];
   logic           next_le [TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      tsst_entry_type prev_entry;
      logic           prev_lt;

      if (i == 0) begin : g_head
         assign prev_entry = '0;
         assign prev_lt    = 1'b1;
      end else begin : g_body
         assign prev_entry = entry[i-1];
         assign prev_lt    = lt[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign next_le[i] = 1'b0;
      end else begin : g_mid
         assign next_le[i] = le[i+1];
      end

      assign le[i] = lt[i] | eq[i];

      tsst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cmd        (cmd),
         .prev_entry (prev_entry),
         .prev_lt    (prev_lt),
         .entry      (entry[i]),
         .lt         (lt[i]),
         .eq         (eq[i])
      );
   end

   // flags form a prefix of the row, so the last set one is the predecessor
   always_comb begin
      stat             = '0;
      stat.full        = entry[TABLE_DEPTH-1].valid;
      stat.found       = le[0];
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         stat.any_eq = stat.any_eq | eq[i];
         if (le[i] && !next_le[i]) begin
            stat.position    = stat.position    | entry[i].position;
            stat.numerator   = stat.numerator   | entry[i].numerator;
            stat.denominator = stat.denominator | entry[i].denominator;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/time_signature_sorted_table_core.sv
`default_nettype none

// Sorted time-signature table with predecessor lookup, held in a row of
// TABLE_DEPTH cells in ascending position order. A word is taken when start
// is high and busy is low; it passes through the compare and apply states
// and its result is registered onto rsp_word with rsp_strobe high for one
// cycle, and cannot be held off. In compare every cell compares the key
// against its entry; in apply the row replaces, shifts up for an insert, is
// read out, or stays as it is when full. A new word may be taken in apply.
// The table is empty after reset with no clearing pass.
module time_signature_sorted_table_core #(
   parameter int TABLE_DEPTH = tsst_pkg::TSST_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tsst_pkg::tsst_req_type req_word,
   output logic                  rsp_strobe,
   output tsst_pkg::tsst_rsp_type rsp_word
);
   import tsst_pkg::*;

   tsst_state_type        state_ff, state_in;
   tsst_req_type          cmd_ff, cmd_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   tsst_rsp_type          rsp_ff, rsp_in;
   tsst_ctrl_type         ctrl;
   tsst_chain_status_type stat;
   logic                  accept;

   assign busy   = (state_ff == ST_COMPARE);
   assign accept = start && !busy;

   always_comb begin
      state_in      = state_ff;
      ctrl          = '0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cmd_in        = accept ? req_word : cmd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = ST_APPLY;
         end
         ST_APPLY: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            if (cmd_ff.mode == MODE_LOOKUP) begin
               if (stat.found) begin
                  rsp_in.status          = STATUS_FOUND;
                  rsp_in.event_position  = stat.position;
                  rsp_in.numerator_out   = stat.numerator;
                  rsp_in.denominator_out = stat.denominator;
               end else begin
                  rsp_in.status          = STATUS_DEFAULT;
                  rsp_in.event_position  = DEFAULT_POSITION;
                  rsp_in.numerator_out   = DEFAULT_NUMERATOR;
                  rsp_in.denominator_out = DEFAULT_DENOMINATOR;
               end
            end else if (stat.any_eq) begin
               ctrl.do_replace = 1'b1;
               rsp_in.status   = STATUS_REPLACED;
            end else if (stat.full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               ctrl.do_insert = 1'b1;
               rsp_in.status  = STATUS_INSERTED;
            end
            state_in = accept ? ST_COMPARE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   tsst_chain #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .cmd   (cmd_ff),
      .stat  (stat)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

`default_nettype wire

>>> design/tsst_checker.sv
`default_nettype none

module tsst_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input tsst_pkg::tsst_req_type req_word,
   input logic                  rsp_strobe,
   input tsst_pkg::tsst_rsp_type rsp_word
);
   import tsst_pkg::*;

   // every word taken is followed by a result strobe
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("no result three edges after a word was taken");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("result without a word taken three edges before");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held beyond the compare cycle");

   a_default_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == STATUS_DEFAULT) |->
         (rsp_word.event_position == DEFAULT_POSITION &&
          rsp_word.numerator_out == DEFAULT_NUMERATOR &&
          rsp_word.denominator_out == DEFAULT_DENOMINATOR))
      else $error("default lookup result is not 4/4 at position 0");

   a_lookup_status: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.mode == MODE_LOOKUP) |-> ##3
         (rsp_word.status == STATUS_FOUND || rsp_word.status == STATUS_DEFAULT))
      else $error("lookup gave an insert status");

endmodule

bind time_signature_sorted_table_core tsst_checker u_checker (.*);

`default_nettype wire
